// ===== sv/gct_pkg.sv =====
// Shared types, codes and connectivity functions for the two-row grid connectivity tree.
package gct_pkg;

  localparam int FIELD_W = 11;

  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_ASK   = 2'd2;

  localparam int F_U = 0;
  localparam int F_D = 1;
  localparam int F_L = 2;
  localparam int F_R = 3;
  localparam int F_P = 4;
  localparam int F_Q = 5;

  localparam logic [5:0] FLAGS_STRAIGHT = 6'b000011;
  localparam logic [5:0] FLAGS_ALL      = 6'b111111;

  typedef enum logic [1:0] {
    OP_ROAD = 2'd0,
    OP_VERT = 2'd1,
    OP_ASK  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic               val;
    logic               row_a;
    logic               row_b;
    logic [FIELD_W-1:0] col_a;
    logic [FIELD_W-1:0] col_b;
  } op_t;

  function automatic logic [5:0] join_flags(input logic [5:0] a, input logic [5:0] b,
                                            input logic t, input logic w);
    logic [5:0] r;
    r[F_L] = a[F_L] | (a[F_U] & t & b[F_L] & w & a[F_D]);
    r[F_R] = b[F_R] | (b[F_U] & t & a[F_R] & w & b[F_D]);
    r[F_U] = (a[F_U] & t & b[F_U]) | (a[F_P] & w & b[F_Q]);
    r[F_D] = (a[F_D] & w & b[F_D]) | (a[F_Q] & t & b[F_P]);
    r[F_P] = (a[F_U] & t & b[F_P]) | (a[F_P] & w & b[F_D]);
    r[F_Q] = (a[F_D] & w & b[F_Q]) | (a[F_Q] & t & b[F_U]);
    return r;
  endfunction

  function automatic logic connected_answer(input logic lr, input logic [5:0] md,
                                            input logic rl, input logic r1, input logic r2);
    logic ok;
    if (r1) begin
      if (r2) ok = md[F_D] | (lr & md[F_U] & rl);
      else    ok = md[F_Q] | (lr & md[F_U]) | (md[F_D] & rl);
    end else begin
      if (r2) ok = md[F_P] | (lr & md[F_D]) | (rl & md[F_U]);
      else    ok = md[F_U] | (lr & md[F_D] & rl);
    end
    return ok;
  endfunction

endpackage

// ===== sv/gct_ifs.sv =====
// Channel interfaces: command beats, result beats and configuration writes.
interface gct_req_if import gct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic               row_a;
  logic [FIELD_W-1:0] col_a;
  logic               row_b;
  logic [FIELD_W-1:0] col_b;
  modport source (output valid, command, row_a, col_a, row_b, col_b, input ready);
  modport sink   (input valid, command, row_a, col_a, row_b, col_b, output ready);
endinterface

interface gct_rsp_if;
  logic valid;
  logic ready;
  logic connected;
  modport source (output valid, connected, input ready);
  modport sink   (input valid, connected, output ready);
endinterface

interface gct_cfg_if import gct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/gct_front.sv =====
// Front end: accepts command beats, range-checks, orders and classifies them.
module gct_front import gct_pkg::*; #(
  parameter int COLUMNS = 1024,
  localparam int CW = $clog2(COLUMNS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  gct_req_if.sink       req,
  input  logic [CW-1:0] n,
  input  logic          clearing,
  output logic          op_valid,
  output op_t           op,
  input  logic          op_ready
);

  logic               keep;
  logic               swap;
  logic [FIELD_W-1:0] x;
  logic [FIELD_W-1:0] y;
  logic               r1;
  logic               r2;
  op_t                cls;

  always_comb begin
    swap = req.col_a > req.col_b;
    x    = swap ? req.col_b : req.col_a;
    y    = swap ? req.col_a : req.col_b;
    r1   = swap ? req.row_b : req.row_a;
    r2   = swap ? req.row_a : req.row_b;
    keep = (req.col_a != '0) && (req.col_b != '0) &&
           (32'(req.col_a) <= 32'(n)) && (32'(req.col_b) <= 32'(n));
    cls.val   = (req.command == CMD_OPEN);
    cls.row_a = r1;
    cls.row_b = r2;
    cls.col_a = x;
    cls.col_b = y;
    cls.kind  = OP_ASK;
    case (req.command)
      CMD_OPEN, CMD_CLOSE: begin
        if (r1 == r2) begin
          cls.kind = OP_ROAD;
          if (32'(x) >= 32'(n)) keep = 1'b0;
        end else begin
          cls.kind = OP_VERT;
        end
      end
      CMD_ASK: cls.kind = OP_ASK;
      default: keep = 1'b0;
    endcase
  end

  assign req.ready = !clearing && (!op_valid || op_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      if (op_valid && op_ready) op_valid <= 1'b0;
      if (req.valid && req.ready && keep) begin
        op_valid <= 1'b1;
        op       <= cls;
      end
    end
  end

endmodule

// ===== sv/gct_queue.sv =====
// Two-entry queue of classified commands between front end and tree engine.
module gct_queue import gct_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  op_t  in_op,
  output logic out_valid,
  input  logic out_ready,
  output op_t  out_op
);

  op_t        entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_op    = entries[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        entries[wp] <= in_op;
        wp          <= ~wp;
      end
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/gct_engine.sv =====
// Tree engine: road and node stores, clearing pass, updates and three-range asks.
module gct_engine import gct_pkg::*; #(
  parameter int COLUMNS = 1024,
  localparam int CW    = $clog2(COLUMNS + 1),
  localparam int NODES = 4 * COLUMNS,
  localparam int NW    = $clog2(NODES),
  localparam int RW    = $clog2(COLUMNS),
  localparam int LV    = $clog2(COLUMNS) + 1,
  localparam int SW    = $clog2(LV),
  localparam int DW    = $clog2(LV + 1)
) (
  input  logic          clk,
  input  logic          rst,
  gct_cfg_if.sink       cfg,
  input  logic          op_valid,
  input  op_t           op,
  output logic          op_ready,
  gct_rsp_if.source     rsp,
  output logic [CW-1:0] n,
  output logic          clearing
);

  typedef enum logic [12:0] {
    ST_CLEAR   = 13'b0000000000001,
    ST_IDLE    = 13'b0000000000010,
    ST_UPD_DN  = 13'b0000000000100,
    ST_UP_A    = 13'b0000000001000,
    ST_UP_B    = 13'b0000000010000,
    ST_UP_C    = 13'b0000000100000,
    ST_Q_DN    = 13'b0000001000000,
    ST_Q_L     = 13'b0000010000000,
    ST_Q_R     = 13'b0000100000000,
    ST_Q_CMB   = 13'b0001000000000,
    ST_Q_FIN   = 13'b0010000000000,
    ST_Q_FIN2  = 13'b0100000000000,
    ST_OUT     = 13'b1000000000000
  } state_t;

  state_t state;

  logic [6:0] node_mem [NODES];
  logic       top_mem  [COLUMNS];
  logic       bot_mem  [COLUMNS];

  logic          node_re;
  logic [NW-1:0] node_ra;
  logic          node_rleaf;
  logic          node_we;
  logic [NW-1:0] node_wa;
  logic [6:0]    node_wd;
  logic [6:0]    node_q;
  logic          node_leaf_q;
  logic [5:0]    node_flags;

  logic          road_re;
  logic [RW-1:0] road_ra;
  logic          top_we;
  logic          bot_we;
  logic [RW-1:0] road_wa;
  logic          road_wd;
  logic          t_q;
  logic          w_q;

  logic [NW-1:0] clr_cnt;

  op_kind_t      kind;
  logic          val;
  logic          r1;
  logic          r2;
  logic [CW-1:0] x;
  logic [CW-1:0] y;

  logic [NW-1:0] idx;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [DW-1:0] d;
  logic [CW-1:0] slo [LV];
  logic [CW-1:0] shi [LV];

  logic [1:0]    qn;
  logic [CW-1:0] qx;
  logic [CW-1:0] qy;
  logic [CW-1:0] split_m;
  logic [NW-1:0] r_idx;
  logic [CW-1:0] r_lo;
  logic [CW-1:0] r_hi;
  logic [5:0]    accl;
  logic [5:0]    accr;
  logic          accl_v;
  logic          accr_v;
  logic [CW-1:0] accr_end;
  logic          cmb_single;
  logic          cmb_left;
  logic          cmb_last;
  logic [CW-1:0] cmb_end;
  logic          lf_r;
  logic [5:0]    md;
  logic          rf_l;

  logic [CW:0]   sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] mid1;
  logic [NW-1:0] idx_l;
  logic [NW-1:0] idx_r;
  logic [NW-1:0] pidx;
  logic [DW-1:0] dm1;
  logic [CW-1:0] plo;
  logic [CW-1:0] phi;
  logic [CW:0]   psum;
  logic [CW-1:0] pm;
  logic          fin;
  logic [5:0]    fin_val;
  logic [CW-1:0] cfg_n;

  assign sum   = {1'b0, lo} + {1'b0, hi};
  assign mid   = sum[CW:1];
  assign mid1  = mid + CW'(1);
  assign idx_l = {idx[NW-2:0], 1'b0};
  assign idx_r = {idx[NW-2:0], 1'b1};
  assign pidx  = {1'b0, idx[NW-1:1]};
  assign dm1   = d - DW'(1);
  assign plo   = slo[dm1[SW-1:0]];
  assign phi   = shi[dm1[SW-1:0]];
  assign psum  = {1'b0, plo} + {1'b0, phi};
  assign pm    = psum[CW:1];

  assign node_flags = node_q[6] ? node_q[5:0] : (node_leaf_q ? FLAGS_STRAIGHT : 6'b0);

  assign op_ready  = state == ST_IDLE;
  assign clearing  = state == ST_CLEAR;
  assign cfg.ready = 1'b1;

  always_comb begin
    if (cfg.data == '0)                 cfg_n = CW'(1);
    else if (32'(cfg.data) > COLUMNS)   cfg_n = CW'(COLUMNS);
    else                                cfg_n = CW'(cfg.data);
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    if (node_re) begin
      node_q      <= node_mem[node_ra];
      node_leaf_q <= node_rleaf;
    end
    if (top_we) top_mem[road_wa] <= road_wd;
    if (bot_we) bot_mem[road_wa] <= road_wd;
    if (road_re) begin
      t_q <= top_mem[road_ra];
      w_q <= bot_mem[road_ra];
    end
  end

  always_comb begin
    node_re    = 1'b0;
    node_ra    = idx;
    node_rleaf = 1'b0;
    node_we    = 1'b0;
    node_wa    = idx;
    node_wd    = 7'b0;
    road_re    = 1'b0;
    road_ra    = '0;
    top_we     = 1'b0;
    bot_we     = 1'b0;
    road_wa    = '0;
    road_wd    = 1'b0;
    fin        = 1'b0;
    fin_val    = node_flags;
    case (state)
      ST_CLEAR: begin
        node_we = 1'b1;
        node_wa = clr_cnt;
        if (32'(clr_cnt) < COLUMNS) begin
          top_we  = 1'b1;
          bot_we  = 1'b1;
          road_wa = RW'(clr_cnt);
        end
      end
      ST_IDLE: begin
        if (op_valid && op.kind == OP_ROAD) begin
          top_we  = !op.row_a;
          bot_we  = op.row_a;
          road_wa = RW'(op.col_a - FIELD_W'(1));
          road_wd = op.val;
        end
      end
      ST_UPD_DN: begin
        if (lo == hi && kind == OP_VERT) begin
          node_we = 1'b1;
          node_wd = {1'b1, val ? FLAGS_ALL : FLAGS_STRAIGHT};
        end
      end
      ST_UP_A: begin
        node_re    = d != '0;
        node_ra    = {idx[NW-1:1], 1'b0};
        node_rleaf = plo == pm;
        road_re    = d != '0;
        road_ra    = RW'(pm - CW'(1));
      end
      ST_UP_B: begin
        node_re    = 1'b1;
        node_ra    = {idx[NW-1:1], 1'b1};
        node_rleaf = (pm + CW'(1)) == phi;
      end
      ST_UP_C: begin
        node_we = 1'b1;
        node_wa = pidx;
        node_wd = {1'b1, join_flags(accl, node_flags, t_q, w_q)};
      end
      ST_Q_DN: begin
        node_re    = qx <= lo && hi <= qy;
        node_rleaf = lo == hi;
      end
      ST_Q_L: begin
        road_ra = RW'(hi - CW'(1));
        if (qx <= lo) begin
          node_re    = 1'b1;
          node_rleaf = lo == hi;
          road_re    = 1'b1;
        end else if (qx <= mid) begin
          node_re    = 1'b1;
          node_ra    = idx_r;
          node_rleaf = mid1 == hi;
          road_re    = 1'b1;
        end
      end
      ST_Q_R: begin
        road_ra = RW'(accr_end - CW'(1));
        if (hi <= qy) begin
          node_re    = 1'b1;
          node_rleaf = lo == hi;
          road_re    = 1'b1;
        end else if (mid < qy) begin
          node_re    = 1'b1;
          node_ra    = idx_l;
          node_rleaf = lo == mid;
          road_re    = 1'b1;
        end
      end
      ST_Q_CMB: begin
        fin = cmb_single;
      end
      ST_Q_FIN: begin
        road_re = 1'b1;
        road_ra = RW'(split_m - CW'(1));
      end
      ST_Q_FIN2: begin
        fin     = 1'b1;
        fin_val = join_flags(accl, accr, t_q, w_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      n         <= CW'(COLUMNS);
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (clr_cnt == NW'(NODES - 1)) state <= ST_IDLE;
          else                           clr_cnt <= clr_cnt + NW'(1);
        end
        ST_IDLE: begin
          if (op_valid) begin
            kind <= op.kind;
            val  <= op.val;
            r1   <= op.row_a;
            r2   <= op.row_b;
            x    <= CW'(op.col_a);
            y    <= CW'(op.col_b);
            idx  <= NW'(1);
            lo   <= CW'(1);
            hi   <= n;
            d    <= '0;
            qn   <= 2'd0;
            qx   <= CW'(1);
            qy   <= CW'(op.col_a);
            state <= (op.kind == OP_ASK) ? ST_Q_DN : ST_UPD_DN;
          end
        end
        ST_UPD_DN: begin
          if (lo != hi) begin
            slo[d[SW-1:0]] <= lo;
            shi[d[SW-1:0]] <= hi;
            d <= d + DW'(1);
            if (x <= mid) begin
              idx <= idx_l;
              hi  <= mid;
            end else begin
              idx <= idx_r;
              lo  <= mid1;
            end
          end else begin
            state <= ST_UP_A;
          end
        end
        ST_UP_A: state <= (d == '0) ? ST_IDLE : ST_UP_B;
        ST_UP_B: begin
          accl  <= node_flags;
          state <= ST_UP_C;
        end
        ST_UP_C: begin
          idx   <= pidx;
          d     <= dm1;
          state <= ST_UP_A;
        end
        ST_Q_DN: begin
          if (qx <= lo && hi <= qy) begin
            cmb_single <= 1'b1;
            state      <= ST_Q_CMB;
          end else if (qy <= mid) begin
            idx <= idx_l;
            hi  <= mid;
          end else if (mid < qx) begin
            idx <= idx_r;
            lo  <= mid1;
          end else begin
            split_m    <= mid;
            r_idx      <= idx_r;
            r_lo       <= mid1;
            r_hi       <= hi;
            idx        <= idx_l;
            hi         <= mid;
            accl_v     <= 1'b0;
            accr_v     <= 1'b0;
            cmb_single <= 1'b0;
            state      <= ST_Q_L;
          end
        end
        ST_Q_L: begin
          if (qx <= lo) begin
            cmb_left <= 1'b1;
            cmb_last <= 1'b1;
            state    <= ST_Q_CMB;
          end else if (qx <= mid) begin
            cmb_left <= 1'b1;
            cmb_last <= 1'b0;
            idx      <= idx_l;
            hi       <= mid;
            state    <= ST_Q_CMB;
          end else begin
            idx <= idx_r;
            lo  <= mid1;
          end
        end
        ST_Q_R: begin
          if (hi <= qy) begin
            cmb_left <= 1'b0;
            cmb_last <= 1'b1;
            cmb_end  <= hi;
            state    <= ST_Q_CMB;
          end else if (mid < qy) begin
            cmb_left <= 1'b0;
            cmb_last <= 1'b0;
            cmb_end  <= mid;
            idx      <= idx_r;
            lo       <= mid1;
            state    <= ST_Q_CMB;
          end else begin
            idx <= idx_l;
            hi  <= mid;
          end
        end
        ST_Q_CMB: begin
          if (!cmb_single) begin
            if (cmb_left) begin
              accl   <= accl_v ? join_flags(node_flags, accl, t_q, w_q) : node_flags;
              accl_v <= 1'b1;
              if (cmb_last) begin
                idx   <= r_idx;
                lo    <= r_lo;
                hi    <= r_hi;
                state <= ST_Q_R;
              end else begin
                state <= ST_Q_L;
              end
            end else begin
              accr     <= accr_v ? join_flags(accr, node_flags, t_q, w_q) : node_flags;
              accr_v   <= 1'b1;
              accr_end <= cmb_end;
              state    <= cmb_last ? ST_Q_FIN : ST_Q_R;
            end
          end
        end
        ST_Q_FIN: state <= ST_Q_FIN2;
        ST_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid     <= 1'b1;
            rsp.connected <= connected_answer(lf_r, md, rf_l, r1, r2);
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (fin) begin
        idx <= NW'(1);
        lo  <= CW'(1);
        hi  <= n;
        case (qn)
          2'd0: begin
            lf_r  <= fin_val[F_R];
            qn    <= 2'd1;
            qx    <= x;
            qy    <= y;
            state <= ST_Q_DN;
          end
          2'd1: begin
            md    <= fin_val;
            qn    <= 2'd2;
            qx    <= y;
            qy    <= n;
            state <= ST_Q_DN;
          end
          default: begin
            rf_l  <= fin_val[F_L];
            state <= ST_OUT;
          end
        endcase
      end
      if (cfg.valid) begin
        n       <= cfg_n;
        clr_cnt <= '0;
        state   <= ST_CLEAR;
      end
    end
  end

endmodule

// ===== sv/grid_2xn_connectivity_tree.sv =====
// Top level of the two-row grid connectivity tree.
//
// Channels: req carries command beats (open, close or ask on two cells),
// rsp carries one connected beat for each in-range ask, cfg writes
// columns_in_use. All are valid/ready; a beat moves when both are high.
// A front stage checks, orders and classifies each beat, a two-entry queue
// holds classified commands, and the tree engine carries them out one at a
// time while the front keeps accepting as long as the queue has room.
// An open or close walks down the tree one level a cycle in the engine, then
// climbs back up with three node-store accesses per level. An ask runs three
// range queries over the node store, which has a single read port. Ignored
// beats take no engine time.
// Reset and every cfg write start a clearing pass over the node and road
// stores; req.ready stays low during it. cfg.ready is always high.
// A stalled rsp holds its beat; the engine then waits with the next result
// while the front and queue keep taking commands until the queue is full.
module grid_2xn_connectivity_tree import gct_pkg::*; #(
  parameter int COLUMNS = 1024,
  localparam int CW = $clog2(COLUMNS + 1)
) (
  input  logic      clk,
  input  logic      rst,
  gct_req_if.sink   req,
  gct_rsp_if.source rsp,
  gct_cfg_if.sink   cfg
);

  logic          f_valid;
  logic          f_ready;
  op_t           f_op;
  logic          q_valid;
  logic          q_ready;
  op_t           q_op;
  logic [CW-1:0] n;
  logic          clearing;

  gct_front #(.COLUMNS(COLUMNS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .n        (n),
    .clearing (clearing),
    .op_valid (f_valid),
    .op       (f_op),
    .op_ready (f_ready)
  );

  gct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_op     (f_op),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_op    (q_op)
  );

  gct_engine #(.COLUMNS(COLUMNS)) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op_valid (q_valid),
    .op       (q_op),
    .op_ready (q_ready),
    .rsp      (rsp),
    .n        (n),
    .clearing (clearing)
  );

endmodule

// ===== sv/gct_checker.sv =====
// Port-level assertions for the grid connectivity tree, bound to the top level.
module gct_checker (
  input logic clk,
  input logic rst,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic cfg_valid,
  input logic cfg_ready
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp beat dropped while stalled");

  a_reset_clear: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("req accepted right after reset");

  a_reset_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid right after reset");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !req_ready)
    else $error("req accepted right after cfg write");

endmodule

bind grid_2xn_connectivity_tree gct_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready)
);
